// ----- src/assert_macros.svh -----
// Assertion macros shared by the assigner RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on the rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/llwa_pkg.sv -----
// Shared types and constants for the least-loaded weighted assigner.
// No dependencies; imported by llwa_cfg and the top level.
package llwa_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_RD_WORKER,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic       REG_WORKERS_IN_USE = 1'b0;
    localparam logic [3:0] WORKERS_RESET      = 4'd8;

endpackage

// ----- src/llwa_cfg.sv -----
// APB register block holding workers_in_use and the clamped worker count.
// Depends on llwa_pkg.
module llwa_cfg
    import llwa_pkg::*;
#(
    parameter int MAX_WORKERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  active_workers
);

    localparam logic [7:0] MAXW_C = 8'(MAX_WORKERS);

    logic [3:0] workers_reg;
    logic [3:0] workers_next;
    logic       reg_sel;
    logic [7:0] cfg_wide;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_WORKERS_IN_USE);

    always_comb
    begin
        workers_next = workers_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            workers_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            workers_reg <= WORKERS_RESET;
        end
        else
        begin
            workers_reg <= workers_next;
        end
    end

    assign prdata   = reg_sel ? {28'd0, workers_reg} : 32'd0;
    assign cfg_wide = {4'd0, workers_reg};

    always_comb
    begin
        if (workers_reg == 4'd0)
        begin
            active_workers = 8'd1;
        end
        else if (cfg_wide > MAXW_C)
        begin
            active_workers = MAXW_C;
        end
        else
        begin
            active_workers = cfg_wide;
        end
    end

endmodule

// ----- src/least_loaded_weighted_assigner.sv -----
// An add runs ST_SCAN, ST_DRAIN, ST_DECIDE, ST_DONE; a remove adds ST_RD_WORKER and ST_WRITE.
// ST_SCAN spans L = max(TABLE_DEPTH, MAX_WORKERS), one read per cycle of the entry memory.
// A new item is taken only in ST_IDLE, once the result is loaded into the output register.
// Reset: asynchronous, active low; a clearing pass over L addresses follows, taking no input.
// Depends on llwa_pkg, llwa_cfg and assert_macros.svh.
module least_loaded_weighted_assigner
    import llwa_pkg::*;
#(
    parameter int MAX_WORKERS = 8,
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // source_id [31:0], weight [47:32]
    input  logic        s_tuser,   // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // worker_index [2:0], worker_load [34:3], zero [39:35]
    output logic [1:0]  m_tuser    // status [1:0]
);

`include "assert_macros.svh"

    localparam int SCAN_LEN = (TABLE_DEPTH > MAX_WORKERS) ? TABLE_DEPTH : MAX_WORKERS;
    localparam int CW       = $clog2(SCAN_LEN + 1);
    localparam int EAW      = $clog2(TABLE_DEPTH);
    localparam int WAW      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int AGE_LO   = 0;
    localparam int WK_LO    = 32;
    localparam int WT_LO    = WK_LO + WAW;
    localparam int SRC_LO   = WT_LO + 16;
    localparam int VLD_BIT  = SRC_LO + 32;
    localparam int EW       = VLD_BIT + 1;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] WCNT_C  = CW'(MAX_WORKERS);
    localparam logic [CW-1:0] LAST_C  = CW'(SCAN_LEN - 1);

    logic [EW-1:0]  ent_mem [TABLE_DEPTH];
    logic [31:0]    wk_mem  [MAX_WORKERS];

    logic [EW-1:0]  ent_q;
    logic [31:0]    wk_q;
    logic           ent_re;
    logic [EAW-1:0] ent_raddr;
    logic           ent_we;
    logic [EAW-1:0] ent_waddr;
    logic [EW-1:0]  ent_wdata;
    logic           wk_re;
    logic [WAW-1:0] wk_raddr;
    logic           wk_we;
    logic [WAW-1:0] wk_waddr;
    logic [31:0]    wk_wdata;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           op_reg;
    logic [31:0]    src_reg;
    logic [15:0]    wt_reg;
    logic           proc_vld_reg, proc_vld_next;
    logic [CW-1:0]  proc_idx_reg;

    logic           slot_found_reg, slot_found_next;
    logic [EAW-1:0] slot_reg, slot_next;
    logic [WAW-1:0] best_idx_reg, best_idx_next;
    logic [31:0]    best_w_reg, best_w_next;
    logic           hit_reg, hit_next;
    logic [EAW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]    hit_dist_reg, hit_dist_next;
    logic [15:0]    hit_wt_reg, hit_wt_next;
    logic [WAW-1:0] hit_wk_reg, hit_wk_next;

    logic [31:0]    add_cnt_reg, add_cnt_next;
    status_t        res_status_reg, res_status_next;
    logic [2:0]     res_wk_reg, res_wk_next;
    logic [31:0]    res_load_reg, res_load_next;

    logic           m_valid_reg, m_valid_next;
    logic [39:0]    m_data_reg;
    logic [1:0]     m_user_reg;
    logic           out_load;

    logic [7:0]     active_workers;
    logic           accept;
    logic           add_commit;
    logic           in_tab;
    logic           e_valid;
    logic [31:0]    e_dist;
    logic [31:0]    add_sum;
    logic [31:0]    sub_diff;

    llwa_cfg #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .active_workers (active_workers)
    );

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_q <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        if (wk_re)
        begin
            wk_q <= wk_mem[wk_raddr];
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_tab     = proc_idx_reg < DEPTH_C;
    assign e_valid    = ent_q[VLD_BIT];
    assign e_dist     = add_cnt_reg - ent_q[WK_LO-1:AGE_LO];
    assign add_sum    = best_w_reg + {16'd0, wt_reg};
    assign sub_diff   = wk_q - {16'd0, hit_wt_reg};
    assign add_commit = (state_reg == ST_DECIDE) && (op_reg == OP_ADD) && slot_found_reg;
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Fold each returned entry and worker word into the running search.
    always_comb
    begin
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        best_idx_next   = best_idx_reg;
        best_w_next     = best_w_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_dist_next   = hit_dist_reg;
        hit_wt_next     = hit_wt_reg;
        hit_wk_next     = hit_wk_reg;
        if (accept)
        begin
            slot_found_next = 1'b0;
            hit_next        = 1'b0;
        end
        else if (proc_vld_reg)
        begin
            if (op_reg == OP_ADD)
            begin
                if (in_tab && !e_valid && !slot_found_reg)
                begin
                    slot_found_next = 1'b1;
                    slot_next       = proc_idx_reg[EAW-1:0];
                end
                if ({{(16-CW){1'b0}}, proc_idx_reg} < {8'd0, active_workers})
                begin
                    if ((proc_idx_reg == '0) || (wk_q < best_w_reg))
                    begin
                        best_idx_next = proc_idx_reg[WAW-1:0];
                        best_w_next   = wk_q;
                    end
                end
            end
            else
            begin
                if (in_tab && e_valid && (ent_q[VLD_BIT-1:SRC_LO] == src_reg))
                begin
                    if (!hit_reg || (e_dist > hit_dist_reg))
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = proc_idx_reg[EAW-1:0];
                        hit_dist_next = e_dist;
                        hit_wt_next   = ent_q[SRC_LO-1:WT_LO];
                        hit_wk_next   = ent_q[WT_LO-1:WK_LO];
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        proc_vld_next   = 1'b0;
        add_cnt_next    = add_cnt_reg;
        res_status_next = res_status_reg;
        res_wk_next     = res_wk_reg;
        res_load_next   = res_load_reg;
        ent_re          = 1'b0;
        ent_raddr       = '0;
        ent_we          = 1'b0;
        ent_waddr       = '0;
        ent_wdata       = '0;
        wk_re           = 1'b0;
        wk_raddr        = '0;
        wk_we           = 1'b0;
        wk_waddr        = '0;
        wk_wdata        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ent_we    = cnt_reg < DEPTH_C;
                ent_waddr = cnt_reg[EAW-1:0];
                wk_we     = cnt_reg < WCNT_C;
                wk_waddr  = cnt_reg[WAW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ent_re        = 1'b1;
                ent_raddr     = (cnt_reg < DEPTH_C) ? cnt_reg[EAW-1:0] : '0;
                wk_re         = 1'b1;
                wk_raddr      = (cnt_reg < WCNT_C) ? cnt_reg[WAW-1:0] : '0;
                proc_vld_next = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (op_reg == OP_ADD)
                begin
                    if (slot_found_reg)
                    begin
                        ent_we          = 1'b1;
                        ent_waddr       = slot_reg;
                        ent_wdata       = {1'b1, src_reg, wt_reg, best_idx_reg, add_cnt_reg};
                        wk_we           = 1'b1;
                        wk_waddr        = best_idx_reg;
                        wk_wdata        = add_sum;
                        add_cnt_next    = add_cnt_reg + 32'd1;
                        res_status_next = STATUS_OK;
                        res_wk_next     = 3'(best_idx_reg);
                        res_load_next   = add_sum;
                    end
                    else
                    begin
                        res_status_next = STATUS_FULL;
                        res_wk_next     = 3'd0;
                        res_load_next   = 32'd0;
                    end
                end
                else if (hit_reg)
                begin
                    state_next = ST_RD_WORKER;
                end
                else
                begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_wk_next     = 3'd0;
                    res_load_next   = 32'd0;
                end
            end
            ST_RD_WORKER:
            begin
                wk_re      = 1'b1;
                wk_raddr   = hit_wk_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wk_we           = 1'b1;
                wk_waddr        = hit_wk_reg;
                wk_wdata        = sub_diff;
                ent_we          = 1'b1;
                ent_waddr       = hit_idx_reg;
                res_status_next = STATUS_OK;
                res_wk_next     = 3'(hit_wk_reg);
                res_load_next   = sub_diff;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            slot_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            add_cnt_reg    <= 32'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            proc_vld_reg   <= proc_vld_next;
            slot_found_reg <= slot_found_next;
            hit_reg        <= hit_next;
            add_cnt_reg    <= add_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            src_reg <= s_tdata[31:0];
            wt_reg  <= s_tdata[47:32];
        end
        proc_idx_reg   <= cnt_reg;
        slot_reg       <= slot_next;
        best_idx_reg   <= best_idx_next;
        best_w_reg     <= best_w_next;
        hit_idx_reg    <= hit_idx_next;
        hit_dist_reg   <= hit_dist_next;
        hit_wt_reg     <= hit_wt_next;
        hit_wk_reg     <= hit_wk_next;
        res_status_reg <= res_status_next;
        res_wk_reg     <= res_wk_next;
        res_load_reg   <= res_load_next;
        if (out_load)
        begin
            m_data_reg <= {5'd0, res_load_reg, res_wk_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_CLK(a_accept_starts_scan, clk, rst_n,
        accept |=> (state_reg == ST_SCAN), "transfer did not start a scan")
    `ASSERT_NEVER(a_no_write_in_scan, clk, rst_n,
        (state_reg == ST_SCAN) && (ent_we || wk_we), "memory written during scan")
    `ASSERT_CLK(a_age_on_add_only, clk, rst_n,
        !$stable(add_cnt_reg) |-> $past(add_commit), "add counter moved without an add")
    `ASSERT_NEVER(a_no_input_in_clear, clk, rst_n,
        (state_reg == ST_CLEAR) && s_tready, "input taken during clearing pass")

endmodule
